// ===== rtl/htw_pkg.sv =====
// ----------------------------------------------------------------------------
// Hierarchical timing wheel: shared definitions
// Constants, command codes and the control and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package htw_pkg;

    localparam int POOL_SIZE_DEF = 64;

    localparam int NBKT       = 132;
    localparam int BKT_W      = 8;
    localparam int MIN_BASE   = 60;
    localparam int HOUR_BASE  = 120;
    localparam int WHEEL_SPAN = 43200;
    localparam int MAX_RES    = 64;
    // 2^32 mod 43200, used when an expiry time wraps past the top of the clock.
    localparam int WRAP_MOD   = 23296;

    localparam int KIND_W  = 2;
    localparam int DELAY_W = 16;
    localparam int ID_W    = 6;
    localparam int STAT_W  = 3;
    localparam int IN_DW   = 24;
    localparam int OUT_DW  = 8;

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;

    localparam logic [STAT_W-1:0] ST_EXPIRED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_ADDED    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FIRE_NOW = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 3'd4;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
    localparam logic [OP_W-1:0] OP_SCAN     = 4'd2;
    localparam logic [OP_W-1:0] OP_ROW_RD   = 4'd3;
    localparam logic [OP_W-1:0] OP_DETACH   = 4'd4;
    localparam logic [OP_W-1:0] OP_ENT_RD   = 4'd5;
    localparam logic [OP_W-1:0] OP_FIRE_ONE = 4'd6;
    localparam logic [OP_W-1:0] OP_CASC_RD  = 4'd7;
    localparam logic [OP_W-1:0] OP_APPEND   = 4'd8;
    localparam logic [OP_W-1:0] OP_ADVANCE  = 4'd9;
    localparam logic [OP_W-1:0] OP_TMOD     = 4'd10;
    localparam logic [OP_W-1:0] OP_DIV1     = 4'd11;
    localparam logic [OP_W-1:0] OP_DIV2     = 4'd12;
    localparam logic [OP_W-1:0] OP_ADD_WR   = 4'd13;
    localparam logic [OP_W-1:0] OP_RESULT   = 4'd14;
    localparam logic [OP_W-1:0] OP_CANCEL   = 4'd15;
    // Flush shares no code with the others: it is a separate flag.

    localparam int BS_W = 2;
    localparam logic [BS_W-1:0] BS_SEC  = 2'd0;
    localparam logic [BS_W-1:0] BS_HOUR = 2'd1;
    localparam logic [BS_W-1:0] BS_MIN0 = 2'd2;
    localparam logic [BS_W-1:0] BS_MIN  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [BS_W-1:0] bsel;
        logic            flush;
    } t_cmd;

    typedef struct packed {
        logic              row_valid;
        logic              walk_last;
        logic              out_free;
        logic              scan_hit;
        logic              scan_end;
        logic [KIND_W-1:0] kind;
        logic              delay_zero;
        logic              delay_long;
        logic              hour_bnd;
        logic              min_bnd;
    } t_sts;

endpackage

// ===== rtl/htw_dp.sv =====
// ----------------------------------------------------------------------------
// Hierarchical timing wheel: datapath
// Timer pool and bucket memories, the wheel clock, the expiry slot arithmetic
// and the result staging and output registers.
// ----------------------------------------------------------------------------
module htw_dp
    import htw_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [DELAY_W-1:0] i_delay,
    input  logic [ID_W-1:0]    i_id,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    output logic [STAT_W-1:0]  o_status,
    output logic [ID_W-1:0]    o_entry_id,
    output logic               o_last
);

    localparam int IW    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int EXP_W = 32 + 4 + 6 + 6;

    // Quotient by 60 for values below 43200: reciprocal estimate, one correction.
    function automatic logic [9:0] div60(input logic [15:0] v);
        logic [32:0] prod;
        logic [15:0] q;
        logic [21:0] back;
        begin
            prod = {17'd0, v} * 33'd1093;
            q    = prod[31:16];
            back = {q, 6'd0} - {4'd0, q, 2'd0};
            if (back > {6'd0, v}) begin
                q = q - 16'd1;
            end
            div60 = q[9:0];
        end
    endfunction

    // Memories.
    logic [2*IW-1:0]  mem_row  [NBKT];
    logic [IW-1:0]    mem_link [POOL_SIZE];
    logic             mem_canc [POOL_SIZE];
    logic [EXP_W-1:0] mem_exp  [POOL_SIZE];

    logic [NBKT-1:0]      r_bvalid;
    logic [POOL_SIZE-1:0] r_live;

    logic [KIND_W-1:0]  r_kind;
    logic [DELAY_W-1:0] r_delay;
    logic [ID_W-1:0]    r_id;

    logic [31:0] r_time;
    logic [15:0] r_ctlin;
    logic [5:0]  r_sec;
    logic [5:0]  r_min;
    logic [3:0]  r_hr;

    logic [IW-1:0]    r_idx;
    logic [IW-1:0]    r_cur;
    logic [IW-1:0]    r_tail;
    logic [IW-1:0]    r_nx;
    logic [BKT_W-1:0] r_bkt;
    logic [BKT_W-1:0] r_tgt;
    logic [2*IW-1:0]  r_row;
    logic             r_row_v;
    logic [IW-1:0]    r_link;
    logic             r_canc;
    logic [EXP_W-1:0] r_exp;

    logic [31:0] r_texp;
    logic [15:0] r_tmod;
    logic [9:0]  r_q;
    logic [5:0]  r_sc;
    logic [5:0]  r_mn;
    logic [3:0]  r_hq;

    logic [6:0]  r_cnt;
    logic        r_pend_v;
    logic [STAT_W-1:0] r_pend_st;
    logic [ID_W-1:0]   r_pend_id;

    logic              r_out_v;
    logic [STAT_W-1:0] r_out_st;
    logic [ID_W-1:0]   r_out_id;
    logic              r_out_last;

    logic [BKT_W-1:0]  row_addr;
    logic              scan_hit;
    logic              out_free;
    logic [10:0]       id_wide;
    logic [IW-1:0]     cidx;
    logic              cancel_ok;
    logic [31:0]       exp_gap;
    logic [BKT_W-1:0]  tgt;
    logic              produce;
    logic [STAT_W-1:0] p_st;
    logic [ID_W-1:0]   p_id;
    logic [10:0]       idx_wide;
    logic [10:0]       cur_wide;
    logic [32:0]       tsum;
    logic signed [18:0] tmod_raw;
    logic [15:0]       tmod_fix;
    logic [9:0]        q1;
    logic [5:0]        hq;
    logic              push;
    logic              push_last;
    logic [STAT_W-1:0] push_st;
    logic [ID_W-1:0]   push_id;

    always_comb begin
        unique case (i_cmd.bsel)
            BS_SEC:  row_addr = {2'd0, r_sec};
            BS_HOUR: row_addr = BKT_W'(HOUR_BASE) + {4'd0, r_hr};
            BS_MIN0: row_addr = BKT_W'(MIN_BASE);
            BS_MIN:  row_addr = BKT_W'(MIN_BASE) + {2'd0, r_min};
            default: row_addr = {2'd0, r_sec};
        endcase
    end

    assign scan_hit  = ~r_live[r_idx];
    assign out_free  = ~r_out_v | i_m_tready;
    assign id_wide   = {5'd0, r_id};
    assign cidx      = id_wide[IW-1:0];
    assign cancel_ok = (id_wide < 11'(POOL_SIZE)) && r_live[cidx];
    assign idx_wide  = 11'(r_idx);
    assign cur_wide  = 11'(r_cur);

    // Slot for an entry from its stored expiry: distance to now picks the level.
    assign exp_gap = r_exp[EXP_W-1 -: 32] - r_time;
    always_comb begin
        if (exp_gap < 32'd60) begin
            tgt = {2'd0, r_exp[5:0]};
        end else if (exp_gap < 32'd3600) begin
            tgt = BKT_W'(MIN_BASE) + {2'd0, r_exp[11:6]};
        end else begin
            tgt = BKT_W'(HOUR_BASE) + {4'd0, r_exp[15:12]};
        end
    end

    // Expiry time modulo half a day, corrected when the 32-bit sum wraps.
    assign tsum = {1'b0, r_time} + {17'd0, r_delay};
    always_comb begin
        tmod_raw = 19'(r_ctlin) + 19'(r_delay) - (tsum[32] ? 19'(WRAP_MOD) : 19'sd0);
        if (tmod_raw < 0) begin
            tmod_raw = tmod_raw + 19'(WHEEL_SPAN);
        end else if (tmod_raw >= 19'(WHEEL_SPAN)) begin
            tmod_raw = tmod_raw - 19'(WHEEL_SPAN);
        end
        tmod_fix = tmod_raw[15:0];
    end

    assign q1 = div60(r_tmod);
    assign hq = 6'(div60({6'd0, r_q}));

    always_comb begin
        produce = 1'b0;
        p_st    = ST_EXPIRED;
        p_id    = '0;
        unique case (i_cmd.op)
            OP_FIRE_ONE: begin
                produce = ~r_canc && (r_cnt < 7'(MAX_RES));
                p_st    = ST_EXPIRED;
                p_id    = cur_wide[ID_W-1:0];
            end
            OP_ADD_WR: begin
                produce = 1'b1;
                p_st    = ST_ADDED;
                p_id    = idx_wide[ID_W-1:0];
            end
            OP_RESULT: begin
                produce = 1'b1;
                if (r_delay == '0) begin
                    p_st = ST_FIRE_NOW;
                    p_id = scan_hit ? idx_wide[ID_W-1:0] : '0;
                end else if (r_delay >= DELAY_W'(WHEEL_SPAN)) begin
                    p_st = ST_TOO_LONG;
                end else begin
                    p_st = ST_FULL;
                end
            end
            default: begin
                produce = 1'b0;
            end
        endcase
    end

    // A result waits in the staging register until the next one shows it was not the last.
    assign push      = (produce | i_cmd.flush) & r_pend_v;
    assign push_last = i_cmd.flush;
    assign push_st   = r_pend_st;
    assign push_id   = r_pend_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= '0;
            r_live   <= '0;
            r_time   <= '0;
            r_ctlin  <= '0;
            r_sec    <= '0;
            r_min    <= '0;
            r_hr     <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_cnt    <= '0;
            r_idx    <= '0;
        end else begin
            if (push) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
            if (produce) begin
                r_pend_v <= 1'b1;
                if (i_cmd.op == OP_FIRE_ONE) begin
                    r_cnt <= r_cnt + 7'd1;
                end
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_idx <= '0;
                    r_cnt <= '0;
                end
                OP_SCAN: begin
                    r_idx <= r_idx + IW'(1);
                end
                OP_DETACH: begin
                    r_bvalid[r_bkt] <= 1'b0;
                end
                OP_FIRE_ONE: begin
                    r_live[r_cur] <= 1'b0;
                end
                OP_APPEND: begin
                    r_bvalid[r_tgt] <= 1'b1;
                end
                OP_ADD_WR: begin
                    r_live[r_idx] <= 1'b1;
                end
                OP_ADVANCE: begin
                    if (r_time == '1) begin
                        r_time  <= '0;
                        r_ctlin <= '0;
                        r_sec   <= '0;
                        r_min   <= '0;
                        r_hr    <= '0;
                    end else begin
                        r_time  <= r_time + 32'd1;
                        r_ctlin <= (r_ctlin == 16'(WHEEL_SPAN - 1)) ? 16'd0 : r_ctlin + 16'd1;
                        if (r_sec == 6'd59) begin
                            r_sec <= '0;
                            if (r_min == 6'd59) begin
                                r_min <= '0;
                                r_hr  <= (r_hr == 4'd11) ? 4'd0 : r_hr + 4'd1;
                            end else begin
                                r_min <= r_min + 6'd1;
                            end
                        end else begin
                            r_sec <= r_sec + 6'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers and memories.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_st   <= push_st;
            r_out_id   <= push_id;
            r_out_last <= push_last;
        end
        if (produce) begin
            r_pend_st <= p_st;
            r_pend_id <= p_id;
        end
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_kind  <= i_kind;
                r_delay <= i_delay;
                r_id    <= i_id;
            end
            OP_ROW_RD: begin
                r_bkt   <= row_addr;
                r_row   <= mem_row[row_addr];
                r_row_v <= r_bvalid[row_addr];
            end
            OP_DETACH: begin
                r_cur  <= r_row[2*IW-1:IW];
                r_tail <= r_row[IW-1:0];
            end
            OP_ENT_RD: begin
                r_link <= mem_link[r_cur];
                r_canc <= mem_canc[r_cur];
                r_exp  <= mem_exp[r_cur];
            end
            OP_FIRE_ONE: begin
                r_cur <= r_link;
            end
            OP_CASC_RD: begin
                r_nx    <= r_link;
                r_tgt   <= tgt;
                r_row   <= mem_row[tgt];
                r_row_v <= r_bvalid[tgt];
            end
            OP_APPEND: begin
                if (r_row_v) begin
                    mem_link[r_row[IW-1:0]] <= r_cur;
                    mem_row[r_tgt] <= {r_row[2*IW-1:IW], r_cur};
                end else begin
                    mem_row[r_tgt] <= {r_cur, r_cur};
                end
                r_cur <= r_nx;
            end
            OP_TMOD: begin
                r_tmod <= tmod_fix;
                r_texp <= tsum[31:0];
            end
            OP_DIV1: begin
                r_q  <= q1;
                r_sc <= 6'(r_tmod - ({q1, 6'd0} - {q1, 2'd0}));
            end
            OP_DIV2: begin
                r_hq <= hq[3:0];
                r_mn <= 6'(r_q - ({hq, 6'd0} - {2'd0, hq, 2'd0}));
            end
            OP_ADD_WR: begin
                mem_exp[r_idx]  <= {r_texp, r_hq, r_mn, r_sc};
                mem_canc[r_idx] <= 1'b0;
                r_cur           <= r_idx;
                r_tail          <= r_idx;
            end
            OP_CANCEL: begin
                if (cancel_ok) begin
                    mem_canc[cidx] <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.row_valid  = r_row_v;
        o_sts.walk_last  = (r_cur == r_tail);
        o_sts.out_free   = out_free;
        o_sts.scan_hit   = scan_hit;
        o_sts.scan_end   = (r_idx == IW'(POOL_SIZE - 1));
        o_sts.kind       = r_kind;
        o_sts.delay_zero = (r_delay == '0);
        o_sts.delay_long = (r_delay >= DELAY_W'(WHEEL_SPAN));
        o_sts.hour_bnd   = (r_sec == '0) && (r_min == '0);
        o_sts.min_bnd    = (r_sec == '0);
    end

    assign o_m_tvalid = r_out_v;
    assign o_status   = r_out_st;
    assign o_entry_id = r_out_id;
    assign o_last     = r_out_last;

endmodule

// ===== rtl/htw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Hierarchical timing wheel: controller
// Sequences ticks and adds as walks over bucket lists, and cancels as a single
// command; it issues at most one datapath command per cycle.
// ----------------------------------------------------------------------------
module htw_ctrl
    import htw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int SW = 5;
    localparam logic [SW-1:0] S_IDLE  = 5'd0;
    localparam logic [SW-1:0] S_DISP  = 5'd1;
    localparam logic [SW-1:0] S_RR    = 5'd2;
    localparam logic [SW-1:0] S_DT    = 5'd3;
    localparam logic [SW-1:0] S_F_RD  = 5'd4;
    localparam logic [SW-1:0] S_F_EX  = 5'd5;
    localparam logic [SW-1:0] S_ADV   = 5'd6;
    localparam logic [SW-1:0] S_BND   = 5'd7;
    localparam logic [SW-1:0] S_C_RD  = 5'd8;
    localparam logic [SW-1:0] S_C_TG  = 5'd9;
    localparam logic [SW-1:0] S_C_AP  = 5'd10;
    localparam logic [SW-1:0] S_SCAN  = 5'd11;
    localparam logic [SW-1:0] S_A_DEC = 5'd12;
    localparam logic [SW-1:0] S_A_TM  = 5'd13;
    localparam logic [SW-1:0] S_A_D1  = 5'd14;
    localparam logic [SW-1:0] S_A_D2  = 5'd15;
    localparam logic [SW-1:0] S_A_WR  = 5'd16;
    localparam logic [SW-1:0] S_FLUSH = 5'd17;

    localparam int PW = 3;
    localparam logic [PW-1:0] PH_FIRE1 = 3'd0;
    localparam logic [PW-1:0] PH_HOUR  = 3'd1;
    localparam logic [PW-1:0] PH_MIN0  = 3'd2;
    localparam logic [PW-1:0] PH_MIN   = 3'd3;
    localparam logic [PW-1:0] PH_FIRE2 = 3'd4;
    localparam logic [PW-1:0] PH_ADD   = 3'd5;

    logic [SW-1:0] r_state, n_state;
    logic [PW-1:0] r_phase, n_phase;
    logic [SW-1:0] end_state;
    logic [PW-1:0] end_phase;
    logic          is_fire;

    assign is_fire = (r_phase == PH_FIRE1) || (r_phase == PH_FIRE2);

    // Where a finished list walk leads.
    always_comb begin
        end_state = S_FLUSH;
        end_phase = r_phase;
        unique case (r_phase)
            PH_FIRE1: end_state = S_ADV;
            PH_HOUR: begin
                end_state = S_RR;
                end_phase = PH_MIN0;
            end
            PH_MIN0, PH_MIN: begin
                end_state = S_RR;
                end_phase = PH_FIRE2;
            end
            default: end_state = S_FLUSH;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        o_cmd.op     = OP_NONE;
        o_cmd.bsel   = BS_SEC;
        o_cmd.flush  = 1'b0;
        o_s_tready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.kind == KIND_TICK) begin
                    n_phase = PH_FIRE1;
                    n_state = S_RR;
                end else if (i_sts.kind == KIND_ADD) begin
                    n_state = S_SCAN;
                end else if (i_sts.kind == KIND_CANCEL) begin
                    o_cmd.op = OP_CANCEL;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RR: begin
                o_cmd.op = OP_ROW_RD;
                unique case (r_phase)
                    PH_HOUR: o_cmd.bsel = BS_HOUR;
                    PH_MIN0: o_cmd.bsel = BS_MIN0;
                    PH_MIN:  o_cmd.bsel = BS_MIN;
                    default: o_cmd.bsel = BS_SEC;
                endcase
                n_state = S_DT;
            end
            S_DT: begin
                if (i_sts.row_valid) begin
                    o_cmd.op = OP_DETACH;
                    n_state  = is_fire ? S_F_RD : S_C_RD;
                end else begin
                    n_state = end_state;
                    n_phase = end_phase;
                end
            end
            S_F_RD: begin
                o_cmd.op = OP_ENT_RD;
                n_state  = S_F_EX;
            end
            S_F_EX: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_FIRE_ONE;
                    if (i_sts.walk_last) begin
                        n_state = end_state;
                        n_phase = end_phase;
                    end else begin
                        n_state = S_F_RD;
                    end
                end
            end
            S_ADV: begin
                o_cmd.op = OP_ADVANCE;
                n_state  = S_BND;
            end
            S_BND: begin
                n_state = S_RR;
                if (i_sts.hour_bnd) begin
                    n_phase = PH_HOUR;
                end else if (i_sts.min_bnd) begin
                    n_phase = PH_MIN;
                end else begin
                    n_phase = PH_FIRE2;
                end
            end
            S_C_RD: begin
                o_cmd.op = OP_ENT_RD;
                n_state  = S_C_TG;
            end
            S_C_TG: begin
                o_cmd.op = OP_CASC_RD;
                n_state  = S_C_AP;
            end
            S_C_AP: begin
                o_cmd.op = OP_APPEND;
                if (i_sts.walk_last) begin
                    n_state = end_state;
                    n_phase = end_phase;
                end else begin
                    n_state = S_C_RD;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_hit || i_sts.scan_end) begin
                    n_state = S_A_DEC;
                end else begin
                    o_cmd.op = OP_SCAN;
                end
            end
            S_A_DEC: begin
                if (i_sts.delay_zero || i_sts.delay_long || !i_sts.scan_hit) begin
                    o_cmd.op = OP_RESULT;
                    n_state  = S_FLUSH;
                end else begin
                    n_state = S_A_TM;
                end
            end
            S_A_TM: begin
                o_cmd.op = OP_TMOD;
                n_state  = S_A_D1;
            end
            S_A_D1: begin
                o_cmd.op = OP_DIV1;
                n_state  = S_A_D2;
            end
            S_A_D2: begin
                o_cmd.op = OP_DIV2;
                n_state  = S_A_WR;
            end
            S_A_WR: begin
                o_cmd.op = OP_ADD_WR;
                n_phase  = PH_ADD;
                n_state  = S_C_RD;
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_FIRE1;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== rtl/hierarchical_timing_wheel.sv =====
// ----------------------------------------------------------------------------
// Hierarchical timing wheel
// Three-level wheel (60 second, 60 minute, 12 hour slots) over a timer pool.
//
//   Channel  | Dir | tdata                          | tuser      | tlast
//   s_       | in  | [15:0] delay_seconds,          | [1:0] kind | -
//            |     | [21:16] timer_id, [23:22] zero |            |
//   m_       | out | [5:0] entry_id, [7:6] zero     | [2:0] status | last
//
// One item is taken at a time. A cancel marks its entry; an add scans the
// pool for a free entry, works out the expiry slot and appends the entry to
// it, or reports a status when refused; a tick fires the second slot, steps
// the clock, cascades hour and minute slots at their boundaries and fires the
// new second slot. Reset is synchronous and leaves every slot empty at once.
// A stalled output holds the walk until the output register frees.
// ----------------------------------------------------------------------------
module hierarchical_timing_wheel
    import htw_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_DW-1:0]  s_tdata,   // delay_seconds, timer_id
    input  logic [KIND_W-1:0] s_tuser,   // kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata,   // entry_id
    output logic [STAT_W-1:0] m_tuser,   // status
    output logic              m_tlast
);

    t_cmd            cmd;
    t_sts            sts;
    logic [ID_W-1:0] entry_id;

    htw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    htw_dp #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_kind     (s_tuser),
        .i_delay    (s_tdata[DELAY_W-1:0]),
        .i_id       (s_tdata[DELAY_W+ID_W-1:DELAY_W]),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_status   (m_tuser),
        .o_entry_id (entry_id),
        .o_last     (m_tlast)
    );

    assign m_tdata = {2'b00, entry_id};

endmodule
